>>> src/resampling_kernel_weight_macros.svh
// ----------------------------------------------------------------------------
// Resampling kernel weight: assertion macros
// Immediate-consequence and next-cycle property wrappers, removable as a set.
// ----------------------------------------------------------------------------
`ifndef RESAMPLING_KERNEL_WEIGHT_MACROS_SVH
`define RESAMPLING_KERNEL_WEIGHT_MACROS_SVH

`ifndef NO_ASSERTIONS

// consequence holds in the same cycle as the antecedent
`define RKW_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define RKW_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RKW_ASSERT_SAME(label, ck, rs, ante, cons, msg)
`define RKW_ASSERT_NEXT(label, ck, rs, ante, cons, msg)

`endif

`endif

>>> src/rkw_pkg.sv
// ----------------------------------------------------------------------------
// Resampling kernel weight: package
// Shared types, kernel codes and fixed widths.
// ----------------------------------------------------------------------------
package rkw_pkg;

  localparam int OFFSET_W = 16;  // offset word, two's complement
  localparam int AW       = 17;  // magnitude of offset, holds 2^15
  localparam int WEIGHT_W = 16;  // Q1.15 weight
  localparam int SUP_W    = 14;  // support radius field
  localparam int PW       = 17;  // pre-weight, cubic path carries 3*weight

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h8000;

  // floor(x/3) = (x * RECIP3) >> RECIP3_SH for any x below 2^PW
  localparam logic [15:0] RECIP3    = 16'd43691;
  localparam int          RECIP3_SH = 17;

  typedef enum logic [1:0] {
    KS_BOX   = 2'd0,
    KS_TRI   = 2'd1,
    KS_BELL  = 2'd2,
    KS_CUBIC = 2'd3
  } kernel_t;

  // which piece of the kernel an offset falls into
  typedef enum logic [2:0] {
    Z_ZERO,
    Z_FULL,
    Z_TRI,
    Z_BELL_IN,
    Z_BELL_OUT,
    Z_CUB_IN,
    Z_CUB_OUT
  } zone_t;

  typedef struct packed {
    logic    vld;
    kernel_t sel;
    zone_t   zone;
  } rkw_ctl_t;

endpackage

>>> src/rkw_powers.sv
// ----------------------------------------------------------------------------
// Resampling kernel weight: square and cube stages
// Two registered multiplier stages giving b^2 and b^3 with control alongside.
// ----------------------------------------------------------------------------
module rkw_powers #(
  parameter int BW = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  rkw_pkg::rkw_ctl_t   ctl_in,
  input  logic [BW-1:0]       b_in,
  output rkw_pkg::rkw_ctl_t   ctl_out,
  output logic [BW-1:0]       b_out,
  output logic [2*BW-1:0]     sq_out,
  output logic [3*BW-1:0]     cu_out
);
  import rkw_pkg::*;

  localparam int SQW = 2 * BW;
  localparam int CUW = 3 * BW;

  rkw_ctl_t         ctl_b;
  logic [BW-1:0]    b_b;
  logic [SQW-1:0]   sq_b;
  logic [SQW-1:0]   sq_next;
  logic [CUW-1:0]   cu_next;

  assign sq_next = SQW'(b_in) * SQW'(b_in);
  assign cu_next = CUW'(sq_b) * CUW'(b_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b   <= '0;
      ctl_out <= '0;
    end else if (adv) begin
      ctl_b   <= ctl_in;
      ctl_out <= ctl_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_b    <= b_in;
      sq_b   <= sq_next;
      b_out  <= b_b;
      sq_out <= sq_b;
      cu_out <= cu_next;
    end
  end

endmodule

>>> src/resampling_kernel_weight.sv
// ----------------------------------------------------------------------------
// Resampling kernel weight
// Box, triangle, bell and cubic B-spline kernels evaluated at a Q4.12 offset.
// ----------------------------------------------------------------------------
// One offset word per clock goes in and one weight word per clock comes out
// while the pipeline is not stalled. The whole pipeline advances together
// whenever the output register is empty or being taken, and in_ready is high
// exactly then; a stall freezes every stage in place. The six stages are:
// input register, magnitude and piece select, square, cube, polynomial sum
// with rounding, and the divide by three for the cubic kernel into the
// output register. kernel_select is sampled with each word as it enters;
// write it only while the block is idle.
`include "resampling_kernel_weight_macros.svh"

module resampling_kernel_weight #(
  parameter int OFFSET_FRAC_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rkw_pkg::OFFSET_W-1:0] offset,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rkw_pkg::WEIGHT_W-1:0]       weight,
  output logic [rkw_pkg::SUP_W-1:0]          support
);
  import rkw_pkg::*;

  localparam int FB  = OFFSET_FRAC_BITS;
  localparam int BW  = FB + 1;            // kernel argument, at most 1.0
  localparam int SQW = 2 * BW;
  localparam int CUW = 3 * BW;
  localparam int CW  = ((FB + 2) > (AW + 1)) ? FB + 2 : AW + 1;  // compares
  localparam int RA  = 3 * FB + 3;        // cubic numerator
  localparam int RB  = 2 * FB + 17;       // bell, scaled by 2^15
  localparam int RW  = ((RA > RB) ? RA : RB) + 1;

  localparam logic [CW-1:0] C_HALF  = CW'(1) << (FB - 1);
  localparam logic [CW-1:0] C_ONE   = CW'(1) << FB;
  localparam logic [CW-1:0] C_3HALF = CW'(3) << (FB - 1);
  localparam logic [CW-1:0] C_TWO   = CW'(1) << (FB + 1);

  localparam logic [RW-1:0] TRI_RND  = RW'(1) << (FB - 1);
  localparam logic [RW-1:0] BIN_RND  = RW'(1) << (2 * FB - 1);
  localparam logic [RW-1:0] BOUT_RND = RW'(1) << (2 * FB);
  localparam logic [RW-1:0] BELL_C   = RW'(3) << (2 * FB - 2);   // 0.75
  localparam logic [RW-1:0] CUB_FOUR = RW'(1) << (3 * FB + 2);   // 4 in x^3 scale
  localparam logic [RW-1:0] CUB_RND  = RW'(3) << (3 * FB - 15);  // half of 6*2^(3F-15)
  localparam int            CUB_SH   = 3 * FB - 14;              // then /3 later

  // global advance: the pipe moves when the output slot is free or taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // configuration register
  kernel_t kernel_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= KS_BOX;
    end else if (cfg_we) begin
      kernel_select <= kernel_t'(cfg_wdata);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic                s1_vld;
  kernel_t             s1_sel;
  logic [OFFSET_W-1:0] s1_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_off <= offset;
      s1_sel <= kernel_select;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitude, kernel piece and its argument
  // --------------------------------------------------------------------------
  logic          neg;
  logic [AW-1:0] a_ext;
  logic [AW-1:0] a_mag;
  logic [CW-1:0] a_c;
  logic [CW-1:0] bc;
  zone_t         zone_next;

  assign neg   = s1_off[OFFSET_W-1];
  assign a_ext = {1'b0, s1_off};
  // most negative offset comes out as exactly 2^15
  assign a_mag = neg ? (AW'(1) << OFFSET_W) - a_ext : a_ext;
  assign a_c   = {{(CW - AW){1'b0}}, a_mag};

  always_comb begin
    zone_next = Z_ZERO;
    bc        = '0;
    case (s1_sel)
      KS_BOX: begin
        // half-open interval (-0.5, 0.5]
        if (neg ? (a_c < C_HALF) : (a_c <= C_HALF)) begin
          zone_next = Z_FULL;
        end
      end
      KS_TRI: begin
        if (a_c < C_ONE) begin
          zone_next = Z_TRI;
          bc        = C_ONE - a_c;
        end
      end
      KS_BELL: begin
        if (a_c < C_HALF) begin
          zone_next = Z_BELL_IN;
          bc        = a_c;
        end else if (a_c < C_3HALF) begin
          zone_next = Z_BELL_OUT;
          bc        = C_3HALF - a_c;
        end
      end
      KS_CUBIC: begin
        if (a_c < C_ONE) begin
          zone_next = Z_CUB_IN;
          bc        = a_c;
        end else if (a_c < C_TWO) begin
          zone_next = Z_CUB_OUT;
          bc        = C_TWO - a_c;
        end
      end
      default: begin
        zone_next = Z_ZERO;
        bc        = '0;
      end
    endcase
  end

  rkw_ctl_t      s2_ctl;
  logic [BW-1:0] s2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl.vld  <= s1_vld;
      s2_ctl.sel  <= s1_sel;
      s2_ctl.zone <= zone_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_b <= bc[BW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 and 4: b^2 then b^3
  // --------------------------------------------------------------------------
  rkw_ctl_t       s4_ctl;
  logic [BW-1:0]  s4_b;
  logic [SQW-1:0] s4_sq;
  logic [CUW-1:0] s4_cu;

  rkw_powers #(
    .BW (BW)
  ) u_powers (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (s2_ctl),
    .b_in    (s2_b),
    .ctl_out (s4_ctl),
    .b_out   (s4_b),
    .sq_out  (s4_sq),
    .cu_out  (s4_cu)
  );

  // --------------------------------------------------------------------------
  // Stage 5: polynomial and round to Q1.15 (cubic keeps 3*w, still /3)
  // --------------------------------------------------------------------------
  logic [RW-1:0] b_r;
  logic [RW-1:0] sq_r;
  logic [RW-1:0] cu_r;
  logic [RW-1:0] acc;
  logic [PW-1:0] pre_next;
  logic          div3_next;

  assign b_r  = RW'(s4_b);
  assign sq_r = RW'(s4_sq);
  assign cu_r = RW'(s4_cu);

  always_comb begin
    acc       = '0;
    div3_next = 1'b0;
    case (s4_ctl.zone)
      Z_FULL:     acc = RW'(WEIGHT_ONE);
      Z_TRI:      acc = ((b_r << 15) + TRI_RND) >> FB;
      Z_BELL_IN:  acc = (((BELL_C - sq_r) << 15) + BIN_RND) >> (2 * FB);
      Z_BELL_OUT: acc = ((sq_r << 15) + BOUT_RND) >> (2 * FB + 1);
      Z_CUB_IN: begin
        // 3a^3 - 6a^2 + 4, all in 2^(3F) scale
        acc = ((cu_r << 1) + cu_r + CUB_FOUR + CUB_RND
               - (sq_r << (FB + 2)) - (sq_r << (FB + 1))) >> CUB_SH;
        div3_next = 1'b1;
      end
      Z_CUB_OUT: begin
        acc       = (cu_r + CUB_RND) >> CUB_SH;
        div3_next = 1'b1;
      end
      default: begin
        acc       = '0;
        div3_next = 1'b0;
      end
    endcase
  end

  assign pre_next = acc[PW-1:0];

  logic          s5_vld;
  kernel_t       s5_sel;
  logic [PW-1:0] s5_pre;
  logic          s5_div3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= s4_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sel  <= s4_ctl.sel;
      s5_pre  <= pre_next;
      s5_div3 <= div3_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: divide by three via reciprocal, support radius, output register
  // --------------------------------------------------------------------------
  logic [PW+15:0]       prod3;
  logic [WEIGHT_W-1:0]  weight_next;
  logic [CW-1:0]        sup_c;

  assign prod3       = (PW + 16)'(s5_pre) * (PW + 16)'(RECIP3);
  assign weight_next = s5_div3 ? prod3[RECIP3_SH +: WEIGHT_W] : s5_pre[WEIGHT_W-1:0];

  always_comb begin
    case (s5_sel)
      KS_BOX:   sup_c = C_HALF;
      KS_TRI:   sup_c = C_ONE;
      KS_BELL:  sup_c = C_3HALF;
      KS_CUBIC: sup_c = C_TWO;
      default:  sup_c = C_HALF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight  <= weight_next;
      support <= sup_c[SUP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic box_done;
  logic box_ok;
  logic cub_done;

  assign box_done = s5_vld && adv && (s5_sel == KS_BOX);
  assign cub_done = s5_vld && adv && (s5_sel == KS_CUBIC);
  assign box_ok   = (weight == '0) || (weight == WEIGHT_ONE);

  `RKW_ASSERT_SAME(a_weight_max, clk, rst, out_valid, weight <= WEIGHT_ONE, "weight above 1.0")
  `RKW_ASSERT_NEXT(a_box_binary, clk, rst, box_done, box_ok, "box weight not 0 or 1")
  `RKW_ASSERT_NEXT(a_cubic_peak, clk, rst, cub_done, weight <= 16'd21845, "cubic above 2/3")

endmodule
